// File: rtl/core/tspc_pkg.sv
// Shared widths, codes, reset values and per-axis control structs for the
// three-axis step pulse controller. No dependencies.
package tspc_pkg;

  localparam int N_AXES  = 3;
  localparam int OP_W    = 2;
  localparam int AXIS_W  = 2;
  localparam int LEN_W   = 10;
  localparam int SPT_W   = 7;
  localparam int PER_W   = 16;
  localparam int POS_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request opcodes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_HOME = 2'd2;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
  // no axis: a move is dropped and the position reads zero
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_TENTH = 2'd0,
    CFG_MOVE_PERIOD     = 2'd1,
    CFG_HOMING_PERIOD   = 2'd2,
    CFG_HOMING_DISTANCE = 2'd3
  } cfg_idx_t;

  localparam logic [SPT_W-1:0] SPT_RST         = 7'd8;
  localparam logic [PER_W-1:0] MOVE_PERIOD_RST = 16'd400;
  localparam logic [PER_W-1:0] HOME_PERIOD_RST = 16'd600;
  localparam logic [PER_W-1:0] HOME_DIST_RST   = 16'd32000;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_SEEK_Z  = 3'b010,
    PH_SEEK_XY = 3'b100
  } phase_t;

  // command to one axis for the request being committed
  typedef struct packed {
    logic             tick;
    logic             limit;
    logic             start;
    logic [PER_W-1:0] target;
    logic             dir;
    logic [PER_W-1:0] period;
    logic             set_pend;
  } axis_cmd_t;

  // axis state after the request is applied
  typedef struct packed {
    logic step;
    logic dir;
    logic busy;
    logic pend;
  } axis_sts_t;

endpackage

// File: rtl/core/tspc_if.sv
// Handshake channels of the step pulse controller: request, result and
// configuration write. Depends on tspc_pkg.
interface tspc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tspc_pkg::OP_W-1:0]      op;
  logic [tspc_pkg::AXIS_W-1:0]    axis;
  logic [tspc_pkg::LEN_W-1:0]     length_tenths;
  logic                           toward_positive;
  logic                           limit_x;
  logic                           limit_y;
  logic                           limit_z;

  modport source (output valid, op, axis, length_tenths, toward_positive,
                  limit_x, limit_y, limit_z, input ready);
  modport sink   (input valid, op, axis, length_tenths, toward_positive,
                  limit_x, limit_y, limit_z, output ready);
endinterface

interface tspc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           step_x;
  logic                           step_y;
  logic                           step_z;
  logic                           dir_x;
  logic                           dir_y;
  logic                           dir_z;
  logic                           busy_x;
  logic                           busy_y;
  logic                           busy_z;
  logic                           homing_active;
  logic                           move_rejected;
  logic signed [tspc_pkg::POS_W-1:0] axis_position;

  modport source (output valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                  busy_x, busy_y, busy_z, homing_active, move_rejected,
                  axis_position, input ready);
  modport sink   (input valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                  busy_x, busy_y, busy_z, homing_active, move_rejected,
                  axis_position, output ready);
endinterface

interface tspc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tspc_pkg::CFG_IDX_W-1:0]    index;
  logic [tspc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/tspc_axis.sv
// One step/dir axis: period divider, step pin toggle, step counter, limit stop.
// Presents the post-request state combinationally. Depends on tspc_pkg.
module tspc_axis (
  input  logic                clk,
  input  logic                rst_n,
  input  tspc_pkg::axis_cmd_t cmd,
  output tspc_pkg::axis_sts_t sts
);
  import tspc_pkg::*;

  logic [PER_W-1:0] div_r, div_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic [PER_W-1:0] sd_r, sd_nxt;
  logic [PER_W-1:0] tgt_r, tgt_nxt;
  logic             step_r, step_nxt;
  logic             en_r, en_nxt;
  logic             dir_r, dir_nxt;
  logic             pend_r, pend_nxt;
  logic             fire;
  logic [PER_W-1:0] sd_inc;

  always_comb begin
    div_nxt  = div_r;
    per_nxt  = per_r;
    sd_nxt   = sd_r;
    tgt_nxt  = tgt_r;
    step_nxt = step_r;
    en_nxt   = en_r;
    dir_nxt  = dir_r;
    pend_nxt = pend_r;
    fire     = (div_r >= per_r);
    sd_inc   = (sd_r == '1) ? sd_r : sd_r + 1'b1;

    if (cmd.tick) begin
      div_nxt = fire ? '0 : div_r + 1'b1;
      if (fire && en_r) begin
        if (!step_r) begin
          step_nxt = 1'b1;
        end else begin
          // falling edge: count a step, then check target and switch
          step_nxt = 1'b0;
          sd_nxt   = sd_inc;
          if (sd_inc >= tgt_r) begin
            sd_nxt = '0;
            en_nxt = 1'b0;
          end
          if (cmd.limit && pend_r) begin
            en_nxt   = 1'b0;
            sd_nxt   = '0;
            pend_nxt = 1'b0;
          end
        end
      end
    end
    if (cmd.set_pend) begin
      pend_nxt = 1'b1;
    end
    // start overrides the tick result; count and divider carry over
    if (cmd.start) begin
      tgt_nxt = cmd.target;
      dir_nxt = cmd.dir;
      per_nxt = cmd.period;
      en_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= '0;
      per_r  <= MOVE_PERIOD_RST;
      sd_r   <= '0;
      tgt_r  <= '0;
      step_r <= 1'b0;
      en_r   <= 1'b0;
      dir_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      div_r  <= div_nxt;
      per_r  <= per_nxt;
      sd_r   <= sd_nxt;
      tgt_r  <= tgt_nxt;
      step_r <= step_nxt;
      en_r   <= en_nxt;
      dir_r  <= dir_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign sts.step = step_nxt;
  assign sts.dir  = dir_nxt;
  assign sts.busy = en_nxt;
  assign sts.pend = pend_nxt;

  // a stopped axis never holds a nonzero step count
  assert property (@(posedge clk) disable iff (!rst_n)
    !en_r |-> (sd_r == '0) || $past(!rst_n))
    else $error("tspc_axis: step count left nonzero on a stopped axis");

  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.tick && !cmd.start && !cmd.set_pend |=> $stable(div_r) && $stable(en_r))
    else $error("tspc_axis: axis state moved without a command");

  // a start always leaves the axis running
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> en_r)
    else $error("tspc_axis: started axis is not running");

endmodule

// File: rtl/core/three_axis_step_pulse_controller.sv
// Top level of the three-axis step/dir pulse controller with homing.
// Depends on tspc_pkg, tspc_if (channels) and tspc_axis.
//
// Usage:
//   in_req   request channel: a timer tick, a move or a start-homing request,
//            with the three switch levels sampled on ticks.
//   out_res  one result per request: step/dir pin levels, busy flags,
//            homing status, move refusal and the named axis position.
//   cfg_wr   register writes (steps per tenth, move period, homing period,
//            homing distance); always ready, applied at once, issue only
//            while no request is in flight.
// Path: a request passes the input register, then the result register, from
//   which out_res takes it.
// Throughput: one request per cycle unless out_res stalls; the axis update is
//   a single pass of divider compare, step counter and 10x7 multiply per request.
// Stall: when out_res.ready is low the result register holds, the input
//   register fills, and in_req.ready drops only when both are full.
// Reset: synchronous, active low; clears all axes, homing and positions and
//   loads the register defaults. No clearing pass.
module three_axis_step_pulse_controller (
  input  logic        clk,
  input  logic        rst_n,
  tspc_in_if.sink     in_req,
  tspc_out_if.source  out_res,
  tspc_cfg_if.sink    cfg_wr
);
  import tspc_pkg::*;

  // configuration
  logic [SPT_W-1:0] spt_r;
  logic [PER_W-1:0] move_per_r, home_per_r, home_dist_r;

  // input register
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [AXIS_W-1:0] s1_axis_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              s1_tp_r;
  logic [N_AXES-1:0] s1_lim_r;

  // result register
  logic                    out_valid_r;
  logic [N_AXES-1:0]       out_step_r, out_dir_r, out_busy_r;
  logic                    out_home_r, out_rej_r;
  logic signed [POS_W-1:0] out_pos_r;

  // block state
  phase_t                  phase_r, phase_nxt;
  logic signed [POS_W-1:0] pos_r   [N_AXES];
  logic signed [POS_W-1:0] pos_nxt [N_AXES];

  axis_cmd_t cmd [N_AXES];
  axis_sts_t sts [N_AXES];

  logic                    adv, in_acc;
  logic                    is_tick, is_move, is_home, go_xy, done_xy;
  logic                    rej;
  logic [N_AXES-1:0]       start_move;
  logic [SPT_W+LEN_W-1:0]  prod;
  logic [PER_W-1:0]        tgt;
  logic signed [POS_W-1:0] pos_sel, pos_moved, pos_out;
  logic [POS_W:0]          sum, diff;

  assign adv           = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready  = !s1_valid_r || adv;
  assign in_acc        = in_req.valid && in_req.ready;
  assign cfg_wr.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r       <= SPT_RST;
      move_per_r  <= MOVE_PERIOD_RST;
      home_per_r  <= HOME_PERIOD_RST;
      home_dist_r <= HOME_DIST_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_STEPS_PER_TENTH: spt_r       <= cfg_wr.data[SPT_W-1:0];
        CFG_MOVE_PERIOD:     move_per_r  <= cfg_wr.data[PER_W-1:0];
        CFG_HOMING_PERIOD:   home_per_r  <= cfg_wr.data[PER_W-1:0];
        CFG_HOMING_DISTANCE: home_dist_r <= cfg_wr.data[PER_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_req.op;
      s1_axis_r <= in_req.axis;
      s1_len_r  <= in_req.length_tenths;
      s1_tp_r   <= in_req.toward_positive;
      s1_lim_r  <= {in_req.limit_z, in_req.limit_y, in_req.limit_x};
    end
  end

  // decode the request being committed
  assign is_tick = adv && (s1_op_r == OP_TICK);
  assign is_move = adv && (s1_op_r == OP_MOVE) && (s1_axis_r != AXIS_NONE);
  assign is_home = adv && (s1_op_r == OP_HOME);

  always_comb begin
    unique case (s1_axis_r)
      AXIS_X:  pos_sel = pos_r[AXIS_X];
      AXIS_Y:  pos_sel = pos_r[AXIS_Y];
      AXIS_Z:  pos_sel = pos_r[AXIS_Z];
      default: pos_sel = '0;
    endcase
  end

  // move target saturates at 16 bits
  assign prod = {{SPT_W{1'b0}}, s1_len_r} * {{LEN_W{1'b0}}, spt_r};
  assign tgt  = (prod[SPT_W+LEN_W-1:PER_W] != '0) ? '1 : prod[PER_W-1:0];

  assign sum  = {pos_sel[POS_W-1], pos_sel} + {{(POS_W+1-LEN_W){1'b0}}, s1_len_r};
  assign diff = {pos_sel[POS_W-1], pos_sel} - {{(POS_W+1-LEN_W){1'b0}}, s1_len_r};

  always_comb begin
    if (s1_tp_r) begin
      pos_moved = (!sum[POS_W] && sum[POS_W-1]) ? 16'sh7FFF : sum[POS_W-1:0];
    end else begin
      pos_moved = (diff[POS_W] && !diff[POS_W-1]) ? 16'sh8000 : diff[POS_W-1:0];
    end
  end

  // x and y refuse to go below zero
  assign rej = is_move && (s1_axis_r != AXIS_Z) && !s1_tp_r && diff[POS_W];

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      start_move[a] = is_move && !rej && (s1_axis_r == AXIS_W'(a));
    end
  end

  assign go_xy   = is_tick && (phase_r == PH_SEEK_Z) && !sts[AXIS_Z].pend;
  assign done_xy = is_tick && (phase_r == PH_SEEK_XY) &&
                   !sts[AXIS_X].pend && !sts[AXIS_Y].pend;

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      cmd[a].tick     = is_tick;
      cmd[a].limit    = s1_lim_r[a];
      cmd[a].set_pend = is_home;
      cmd[a].start    = start_move[a];
      cmd[a].target   = tgt;
      cmd[a].period   = move_per_r;
      cmd[a].dir      = (AXIS_W'(a) == AXIS_X) ? s1_tp_r : !s1_tp_r;
    end
    // homing legs: z toward negative first, then x and y
    if (go_xy) begin
      cmd[AXIS_X].start  = 1'b1;
      cmd[AXIS_X].target = home_dist_r;
      cmd[AXIS_X].period = home_per_r;
      cmd[AXIS_X].dir    = 1'b0;
      cmd[AXIS_Y].start  = 1'b1;
      cmd[AXIS_Y].target = home_dist_r;
      cmd[AXIS_Y].period = home_per_r;
      cmd[AXIS_Y].dir    = 1'b1;
    end
    if (is_home) begin
      cmd[AXIS_Z].start  = 1'b1;
      cmd[AXIS_Z].target = home_dist_r;
      cmd[AXIS_Z].period = home_per_r;
      cmd[AXIS_Z].dir    = 1'b1;
    end
  end

  for (genvar g = 0; g < N_AXES; g++) begin : g_axis
    tspc_axis u_axis (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[g]),
      .sts   (sts[g])
    );
  end

  always_comb begin
    priority if (is_home) begin
      phase_nxt = PH_SEEK_Z;
    end else if (go_xy) begin
      phase_nxt = PH_SEEK_XY;
    end else if (done_xy) begin
      phase_nxt = PH_IDLE;
    end else begin
      phase_nxt = phase_r;
    end
  end

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      pos_nxt[a] = start_move[a] ? pos_moved : pos_r[a];
    end
    if (done_xy) begin
      pos_nxt[AXIS_X] = '0;
      pos_nxt[AXIS_Y] = '0;
    end
  end

  always_comb begin
    unique case (s1_axis_r)
      AXIS_X:  pos_out = pos_nxt[AXIS_X];
      AXIS_Y:  pos_out = pos_nxt[AXIS_Y];
      AXIS_Z:  pos_out = pos_nxt[AXIS_Z];
      default: pos_out = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      for (int a = 0; a < N_AXES; a++) begin
        pos_r[a] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      for (int a = 0; a < N_AXES; a++) begin
        pos_r[a] <= pos_nxt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < N_AXES; a++) begin
        out_step_r[a] <= sts[a].step;
        out_dir_r[a]  <= sts[a].dir;
        out_busy_r[a] <= sts[a].busy;
      end
      out_home_r <= (phase_nxt != PH_IDLE);
      out_rej_r  <= rej;
      out_pos_r  <= pos_out;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.step_x        = out_step_r[AXIS_X];
  assign out_res.step_y        = out_step_r[AXIS_Y];
  assign out_res.step_z        = out_step_r[AXIS_Z];
  assign out_res.dir_x         = out_dir_r[AXIS_X];
  assign out_res.dir_y         = out_dir_r[AXIS_Y];
  assign out_res.dir_z         = out_dir_r[AXIS_Z];
  assign out_res.busy_x        = out_busy_r[AXIS_X];
  assign out_res.busy_y        = out_busy_r[AXIS_Y];
  assign out_res.busy_z        = out_busy_r[AXIS_Z];
  assign out_res.homing_active = out_home_r;
  assign out_res.move_rejected = out_rej_r;
  assign out_res.axis_position = out_pos_r;

  // x and y positions never drop below zero
  assert property (@(posedge clk) disable iff (!rst_n)
    !pos_r[AXIS_X][POS_W-1] && !pos_r[AXIS_Y][POS_W-1])
    else $error("tspc: x or y position went negative");

  // positions and homing phase change only on a committed request
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r) && $stable(pos_r[AXIS_X]) &&
             $stable(pos_r[AXIS_Y]) && $stable(pos_r[AXIS_Z]))
    else $error("tspc: state moved without a request");

  // a homing request always restarts the sequence at z
  assert property (@(posedge clk) disable iff (!rst_n)
    is_home |=> (phase_r == PH_SEEK_Z) && out_valid_r && out_res.homing_active)
    else $error("tspc: homing request did not restart at z");

  // a refusal leaves the axis position untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    rej |=> out_valid_r && out_rej_r && $stable(pos_r[AXIS_X]) && $stable(pos_r[AXIS_Y]))
    else $error("tspc: refused move changed a position");

endmodule

// File: verif/tspc_pin_state_check.sv
`timescale 1ns / 1ps
// Predicts the pin, busy, homing and position result of every request to the
// step pulse controller and compares it with what the block returns.
// Depends on tspc_pkg and the channel interfaces in tspc_if.
module tspc_pin_state_check (
  input  logic clk,
  input  logic rst_n,
  tspc_in_if   req,
  tspc_out_if  res,
  tspc_cfg_if  cfg,
  output int   n_fail,
  output int   n_pending,
  output int   n_checked,
  output int   n_refused,
  output int   n_homed
);
  import tspc_pkg::*;

  typedef struct packed {
    logic step_x;
    logic step_y;
    logic step_z;
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic busy_x;
    logic busy_y;
    logic busy_z;
    logic homing_active;
    logic move_rejected;
    logic signed [POS_W-1:0] axis_position;
  } pin_state_t;

  pin_state_t pin_state_q[$];

  // register shadow
  logic [SPT_W-1:0] spt;
  logic [PER_W-1:0] mper;
  logic [PER_W-1:0] hper;
  logic [PER_W-1:0] hdist;

  // axis state
  logic [PER_W-1:0] div_cnt[N_AXES];
  logic [PER_W-1:0] per_val[N_AXES];
  logic [PER_W-1:0] done_cnt[N_AXES];
  logic [PER_W-1:0] tgt[N_AXES];
  logic             stp[N_AXES];
  logic             en[N_AXES];
  logic             dir[N_AXES];
  logic             pend[N_AXES];
  int               axis_tenths[N_AXES];
  phase_t           hm_phase;

  function automatic int clamp_pos(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic clear_state();
    spt   = SPT_RST;
    mper  = MOVE_PERIOD_RST;
    hper  = HOME_PERIOD_RST;
    hdist = HOME_DIST_RST;
    for (int a = 0; a < N_AXES; a++) begin
      div_cnt[a]     = '0;
      per_val[a]     = MOVE_PERIOD_RST;
      done_cnt[a]    = '0;
      tgt[a]         = '0;
      stp[a]         = 1'b0;
      en[a]          = 1'b0;
      dir[a]         = 1'b0;
      pend[a]        = 1'b0;
      axis_tenths[a] = 0;
    end
    hm_phase = PH_IDLE;
  endtask

  task automatic launch_axis(input int a, input logic [PER_W-1:0] target,
                             input logic d, input logic [PER_W-1:0] period);
    tgt[a]     = target;
    dir[a]     = d;
    per_val[a] = period;
    en[a]      = 1'b1;
  endtask

  // one tick of an axis divider; falling step edges count toward the target
  task automatic pulse_axis(input int a, input logic lim);
    logic fire;
    fire = 1'b0;
    if (div_cnt[a] >= per_val[a]) begin
      div_cnt[a] = '0;
      fire = 1'b1;
    end else begin
      div_cnt[a] = div_cnt[a] + 16'd1;
    end
    if (fire && en[a]) begin
      if (!stp[a]) begin
        stp[a] = 1'b1;
      end else begin
        stp[a] = 1'b0;
        if (done_cnt[a] != 16'hFFFF) done_cnt[a] = done_cnt[a] + 16'd1;
        if (done_cnt[a] >= tgt[a]) begin
          done_cnt[a] = '0;
          en[a] = 1'b0;
        end
        // switch found while seeking home
        if (lim && pend[a]) begin
          en[a] = 1'b0;
          done_cnt[a] = '0;
          pend[a] = 1'b0;
        end
      end
    end
  endtask

  task automatic predict_pins(input logic [OP_W-1:0] op, input logic [AXIS_W-1:0] ax,
                              input logic [LEN_W-1:0] len, input logic tp,
                              input logic [2:0] lim, output pin_state_t e);
    int   prod;
    int   ln;
    int   a;
    logic refused;
    refused = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < N_AXES; i++) pulse_axis(i, lim[i]);
        if (hm_phase == PH_SEEK_Z && !pend[2]) begin
          launch_axis(0, hdist, 1'b0, hper);
          launch_axis(1, hdist, 1'b1, hper);
          hm_phase = PH_SEEK_XY;
        end else if (hm_phase == PH_SEEK_XY && !pend[0] && !pend[1]) begin
          axis_tenths[0] = 0;
          axis_tenths[1] = 0;
          hm_phase = PH_IDLE;
          n_homed++;
        end
      end
      OP_MOVE: begin
        if (ax <= AXIS_Z) begin
          a    = int'(ax);
          ln   = int'(len);
          prod = ln * int'(spt);
          if (prod > 65535) prod = 65535;
          if (tp) begin
            axis_tenths[a] = clamp_pos(axis_tenths[a] + ln);
          end else if (ax != AXIS_Z && axis_tenths[a] - ln < 0) begin
            // x and y never go below zero
            refused = 1'b1;
            n_refused++;
          end else begin
            axis_tenths[a] = clamp_pos(axis_tenths[a] - ln);
          end
          if (!refused) launch_axis(a, 16'(prod), (ax == AXIS_X) ? tp : !tp, mper);
        end
      end
      OP_HOME: begin
        for (int i = 0; i < N_AXES; i++) pend[i] = 1'b1;
        launch_axis(2, hdist, 1'b1, hper);
        hm_phase = PH_SEEK_Z;
      end
      default: ;
    endcase
    e.step_x        = stp[0];
    e.step_y        = stp[1];
    e.step_z        = stp[2];
    e.dir_x         = dir[0];
    e.dir_y         = dir[1];
    e.dir_z         = dir[2];
    e.busy_x        = en[0];
    e.busy_y        = en[1];
    e.busy_z        = en[2];
    e.homing_active = (hm_phase != PH_IDLE);
    e.move_rejected = refused;
    e.axis_position = (ax <= AXIS_Z) ? 16'(axis_tenths[int'(ax)]) : '0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : watch
    pin_state_t want;
    pin_state_t seen;
    if (!rst_n) begin
      clear_state();
      pin_state_q.delete();
      n_fail    = 0;
      n_checked = 0;
      n_refused = 0;
      n_homed   = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_STEPS_PER_TENTH: spt   = cfg.data[SPT_W-1:0];
          CFG_MOVE_PERIOD:     mper  = cfg.data;
          CFG_HOMING_PERIOD:   hper  = cfg.data;
          CFG_HOMING_DISTANCE: hdist = cfg.data;
          default: ;
        endcase
      end
      // compare before predicting: a request never returns at its own edge
      if (res.valid && res.ready) begin
        seen = '{res.step_x, res.step_y, res.step_z, res.dir_x, res.dir_y, res.dir_z,
                 res.busy_x, res.busy_y, res.busy_z, res.homing_active,
                 res.move_rejected, res.axis_position};
        if (pin_state_q.size() == 0) begin
          $error("result with no request outstanding");
          n_fail++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("step_x", want.step_x, seen.step_x);
          check_field("step_y", want.step_y, seen.step_y);
          check_field("step_z", want.step_z, seen.step_z);
          check_field("dir_x", want.dir_x, seen.dir_x);
          check_field("dir_y", want.dir_y, seen.dir_y);
          check_field("dir_z", want.dir_z, seen.dir_z);
          check_field("busy_x", want.busy_x, seen.busy_x);
          check_field("busy_y", want.busy_y, seen.busy_y);
          check_field("busy_z", want.busy_z, seen.busy_z);
          check_field("homing_active", want.homing_active, seen.homing_active);
          check_field("move_rejected", want.move_rejected, seen.move_rejected);
          check_field("axis_position", int'(want.axis_position), int'(seen.axis_position));
          n_checked++;
        end
      end
      if (req.valid && req.ready) begin
        predict_pins(req.op, req.axis, req.length_tenths, req.toward_positive,
                     {req.limit_z, req.limit_y, req.limit_x}, want);
        pin_state_q.push_back(want);
      end
    end
    n_pending = pin_state_q.size();
  end

endmodule

// File: verif/tb_three_axis_step_pulse_controller.sv
`timescale 1ns / 1ps
// Top of the step pulse controller testbench: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on tspc_pkg, tspc_if, the block and tspc_pin_state_check.
module tb_three_axis_step_pulse_controller;
  import tspc_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_refused;
  int n_homed;
  int n_sent;
  int n_settings;
  int gap_pct;
  int stall_pct;

  logic [AXIS_W-1:0] axes[N_AXES] = '{AXIS_X, AXIS_Y, AXIS_Z};

  tspc_in_if  in_ch ();
  tspc_out_if out_ch ();
  tspc_cfg_if cfg_ch ();

  three_axis_step_pulse_controller u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch),
    .cfg_wr  (cfg_ch)
  );

  tspc_pin_state_check u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_ch),
    .res       (out_ch),
    .cfg       (cfg_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked),
    .n_refused (n_refused),
    .n_homed   (n_homed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  // result back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) hold = pick_gap();
      end
    end
  end

  // valid stays high across back-to-back requests
  task automatic send_req(input logic [OP_W-1:0] op, input logic [AXIS_W-1:0] ax,
                          input logic [LEN_W-1:0] len, input logic tp,
                          input logic [2:0] lim);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.op              <= op;
    in_ch.axis            <= ax;
    in_ch.length_tenths   <= len;
    in_ch.toward_positive <= tp;
    in_ch.limit_x         <= lim[0];
    in_ch.limit_y         <= lim[1];
    in_ch.limit_z         <= lim[2];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_sent++;
  endtask

  task automatic send_tick(input int lim_pct);
    logic [2:0] lim;
    logic [AXIS_W-1:0] ax;
    for (int i = 0; i < 3; i++) lim[i] = ($urandom_range(0, 99) < lim_pct);
    ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE : axes[$urandom_range(0, 2)];
    send_req(OP_TICK, ax, LEN_W'($urandom), 1'($urandom), lim);
  endtask

  task automatic send_move(input logic [AXIS_W-1:0] ax);
    logic [LEN_W-1:0] len;
    len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 1023))
                                      : LEN_W'($urandom_range(0, 8));
    send_req(OP_MOVE, ax, len, 1'($urandom), 3'($urandom));
  endtask

  // stop requests and let every result come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (n_pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(input int spt, input int mp, input int hp, input int hd);
    drain();
    write_reg(CFG_STEPS_PER_TENTH, CFG_DATA_W'(spt));
    write_reg(CFG_MOVE_PERIOD, CFG_DATA_W'(mp));
    write_reg(CFG_HOMING_PERIOD, CFG_DATA_W'(hp));
    write_reg(CFG_HOMING_DISTANCE, CFG_DATA_W'(hd));
    n_settings++;
  endtask

  // mostly tick runs, moves and homing sequences; with a budget of 100 or more,
  // one burst of full-length moves drives a position into saturation
  task automatic run_random(input int budget, input logic [AXIS_W-1:0] sat_axis,
                            input logic sat_dir);
    int stop_at;
    int kind;
    int lim_pct;
    bit sat_done;
    stop_at  = n_sent + budget;
    sat_done = (budget < 100);
    while (n_sent < stop_at) begin
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      lim_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
      if (!sat_done && n_sent > stop_at - budget / 2) begin
        sat_done = 1'b1;
        repeat (34) send_req(OP_MOVE, sat_axis, 10'd1023, sat_dir, 3'b000);
        continue;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        repeat ($urandom_range(1, 40)) send_tick(lim_pct);
      end else if (kind < 75) begin
        send_move(axes[$urandom_range(0, 2)]);
        repeat ($urandom_range(0, 12)) send_tick(lim_pct);
      end else if (kind < 88) begin
        send_req(OP_HOME, axes[$urandom_range(0, 2)], LEN_W'($urandom), 1'($urandom),
                 3'($urandom));
        repeat ($urandom_range(20, 200)) send_tick(lim_pct);
      end else if (kind < 94) begin
        send_req(OP_UNUSED, AXIS_NONE + 2'($urandom), LEN_W'($urandom), 1'($urandom),
                 3'($urandom));
      end else begin
        send_move(AXIS_NONE);
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    n_sent                = 0;
    n_settings            = 0;
    gap_pct               = 0;
    stall_pct             = 0;
    in_ch.valid           = 1'b0;
    in_ch.op              = OP_TICK;
    in_ch.axis            = AXIS_X;
    in_ch.length_tenths   = '0;
    in_ch.toward_positive = 1'b0;
    in_ch.limit_x         = 1'b0;
    in_ch.limit_y         = 1'b0;
    in_ch.limit_z         = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_STEPS_PER_TENTH;
    cfg_ch.data           = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults
    send_req(OP_MOVE, AXIS_X, 10'd3, 1'b1, 3'b000);
    send_req(OP_TICK, AXIS_X, 10'd0, 1'b0, 3'b000);

    // edge cases with a move divider that fires every tick
    set_regs(1, 0, 1, 4);
    send_req(OP_MOVE, AXIS_X, 10'd1023, 1'b1, 3'b000);
    send_req(OP_MOVE, AXIS_Y, 10'd0, 1'b1, 3'b000);
    repeat (3) send_req(OP_TICK, AXIS_Y, 10'd0, 1'b0, 3'b000);
    send_req(OP_MOVE, AXIS_Z, 10'd5, 1'b0, 3'b000);
    send_req(OP_MOVE, AXIS_X, 10'd1026, 1'b0, 3'b000);
    send_req(OP_MOVE, AXIS_X, 10'd1, 1'b0, 3'b000);
    send_req(OP_MOVE, AXIS_Y, 10'd1, 1'b0, 3'b000);
    send_req(OP_MOVE, AXIS_NONE, 10'd7, 1'b1, 3'b111);
    send_req(OP_UNUSED, AXIS_Z, 10'd1023, 1'b1, 3'b111);
    send_req(OP_TICK, AXIS_Z, 10'd0, 1'b0, 3'b111);
    send_req(OP_HOME, AXIS_X, 10'd0, 1'b0, 3'b000);
    repeat (10) send_req(OP_TICK, AXIS_X, 10'd0, 1'b0, 3'b111);

    run_random(470, AXIS_X, 1'b1);
    set_regs(64, 2, 0, 16);
    run_random(480, AXIS_Z, 1'b0);
    set_regs(127, 1, 2, 1);
    run_random(480, AXIS_Y, 1'b1);
    set_regs(5, 65535, 65535, 65535);
    run_random(40, AXIS_X, 1'b1);
    set_regs(3, 3, 1, 10);
    run_random(480, AXIS_Z, 1'b1);

    drain();
    repeat (8) @(negedge clk);
    $display("Run covered %0d requests under %0d register settings: %0d results checked,",
             n_sent, n_settings + 1, n_checked);
    $display("%0d moves refused below zero, %0d homing sequences completed.",
             n_refused, n_homed);
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tspc_pkg.sv
rtl/core/tspc_if.sv
rtl/core/tspc_axis.sv
rtl/core/three_axis_step_pulse_controller.sv
verif/tspc_pin_state_check.sv
verif/tb_three_axis_step_pulse_controller.sv
